// File: rtl/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// shared types and constants of the line segment intersection block
// ----------------------------------------------------------------------------
package lsi_pkg;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } lsi_status_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

endpackage

// File: rtl/lsi_in_if.sv
// ----------------------------------------------------------------------------
// lsi_in_if
// segment pair channel: valid, ready and two segments
// ----------------------------------------------------------------------------
interface lsi_in_if #(
  parameter int CB = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] a0_x;
  logic signed [CB-1:0] a0_y;
  logic signed [CB-1:0] a1_x;
  logic signed [CB-1:0] a1_y;
  logic signed [CB-1:0] b0_x;
  logic signed [CB-1:0] b0_y;
  logic signed [CB-1:0] b1_x;
  logic signed [CB-1:0] b1_y;

  modport source (output valid, a0_x, a0_y, a1_x, a1_y, b0_x, b0_y, b1_x, b1_y,
                  input ready);
  modport sink (input valid, a0_x, a0_y, a1_x, a1_y, b0_x, b0_y, b1_x, b1_y,
                output ready);
endinterface

// File: rtl/lsi_out_if.sv
// ----------------------------------------------------------------------------
// lsi_out_if
// crossing result channel: valid, ready, status and crossing point
// ----------------------------------------------------------------------------
interface lsi_out_if #(
  parameter int CB = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic signed [CB-1:0] cross_x;
  logic signed [CB-1:0] cross_y;

  modport source (output valid, status, cross_x, cross_y, input ready);
  modport sink (input valid, status, cross_x, cross_y, output ready);
endinterface

// File: rtl/lsi_front.sv
// ----------------------------------------------------------------------------
// lsi_front
// six stage pipeline: determinant, cramer numerators, bounds, status
// ----------------------------------------------------------------------------
module lsi_front #(
  parameter int CB  = 16,
  parameter int NW  = 3 * CB + 4,
  parameter int DW  = 2 * CB + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CB-1:0] x1,
  input  logic signed [CB-1:0] y1,
  input  logic signed [CB-1:0] x2,
  input  logic signed [CB-1:0] y2,
  input  logic signed [CB-1:0] x3,
  input  logic signed [CB-1:0] y3,
  input  logic signed [CB-1:0] x4,
  input  logic signed [CB-1:0] y4,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [1:0]           q_status,
  output logic signed [NW-1:0] q_nx,
  output logic signed [NW-1:0] q_ny,
  output logic signed [DW-1:0] q_den
);
  import lsi_pkg::*;

  localparam int DIF = CB + 1;
  localparam int PRD = 2 * CB;
  localparam int PP  = 2 * CB + 1;
  localparam int DM  = 2 * DIF;
  localparam int NP  = PP + DIF;
  localparam int BP  = CB + DW;

  logic en;
  logic [5:0] v_r;

  // stage 1
  logic signed [DIF-1:0] dxa_r, dya_r, dxb_r, dyb_r;
  logic signed [PRD-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [CB-1:0]  xlo1_r, xhi1_r, ylo1_r, yhi1_r;
  // stage 2
  logic signed [DIF-1:0] dxa2_r, dya2_r, dxb2_r, dyb2_r;
  logic signed [PP-1:0]  pre_r, post_r;
  logic signed [DM-1:0]  m1_r, m2_r;
  logic signed [CB-1:0]  xlo2_r, xhi2_r, ylo2_r, yhi2_r;
  // stage 3
  logic signed [DW-1:0]  d_r;
  logic signed [NP-1:0]  n1_r, n2_r, n3_r, n4_r;
  logic signed [CB-1:0]  xlo3_r, xhi3_r, ylo3_r, yhi3_r;
  // stage 4
  logic signed [NW-1:0]  nx4_r, ny4_r;
  logic signed [DW-1:0]  ad4_r;
  logic                  par4_r;
  logic signed [CB-1:0]  xlo4_r, xhi4_r, ylo4_r, yhi4_r;
  // stage 5
  logic signed [NW-1:0]  nx5_r, ny5_r;
  logic signed [DW-1:0]  ad5_r;
  logic                  par5_r;
  logic signed [BP-1:0]  bxlo_r, bxhi_r, bylo_r, byhi_r;
  // stage 6
  logic signed [NW-1:0]  nx6_r, ny6_r;
  logic signed [DW-1:0]  ad6_r;
  lsi_status_t           st6_r;

  lsi_status_t st_nxt;
  logic        outside;

  assign en       = !(v_r[5] && q_full);
  assign in_ready = en;
  assign q_push   = v_r[5] && !q_full;
  assign q_status = st6_r;
  assign q_nx     = nx6_r;
  assign q_ny     = ny6_r;
  assign q_den    = ad6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_comb begin
    outside = (NW'(bxlo_r) > nx5_r) || (nx5_r > NW'(bxhi_r)) ||
              (NW'(bylo_r) > ny5_r) || (ny5_r > NW'(byhi_r));
    if (par5_r) begin
      st_nxt = ST_PARALLEL;
    end else if (outside) begin
      st_nxt = ST_OUTSIDE;
    end else begin
      st_nxt = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxa_r  <= DIF'(x1) - DIF'(x2);
      dya_r  <= DIF'(y1) - DIF'(y2);
      dxb_r  <= DIF'(x3) - DIF'(x4);
      dyb_r  <= DIF'(y3) - DIF'(y4);
      pa_r   <= PRD'(x1) * PRD'(y2);
      pb_r   <= PRD'(y1) * PRD'(x2);
      pc_r   <= PRD'(x3) * PRD'(y4);
      pd_r   <= PRD'(y3) * PRD'(x4);
      xlo1_r <= ((x1 < x2 ? x1 : x2) > (x3 < x4 ? x3 : x4)) ?
                (x1 < x2 ? x1 : x2) : (x3 < x4 ? x3 : x4);
      xhi1_r <= ((x1 > x2 ? x1 : x2) < (x3 > x4 ? x3 : x4)) ?
                (x1 > x2 ? x1 : x2) : (x3 > x4 ? x3 : x4);
      ylo1_r <= ((y1 < y2 ? y1 : y2) > (y3 < y4 ? y3 : y4)) ?
                (y1 < y2 ? y1 : y2) : (y3 < y4 ? y3 : y4);
      yhi1_r <= ((y1 > y2 ? y1 : y2) < (y3 > y4 ? y3 : y4)) ?
                (y1 > y2 ? y1 : y2) : (y3 > y4 ? y3 : y4);

      dxa2_r <= dxa_r;
      dya2_r <= dya_r;
      dxb2_r <= dxb_r;
      dyb2_r <= dyb_r;
      pre_r  <= PP'(pa_r) - PP'(pb_r);
      post_r <= PP'(pc_r) - PP'(pd_r);
      m1_r   <= DM'(dxa_r) * DM'(dyb_r);
      m2_r   <= DM'(dya_r) * DM'(dxb_r);
      xlo2_r <= xlo1_r;
      xhi2_r <= xhi1_r;
      ylo2_r <= ylo1_r;
      yhi2_r <= yhi1_r;

      d_r    <= DW'(m1_r) - DW'(m2_r);
      n1_r   <= NP'(pre_r) * NP'(dxb2_r);
      n2_r   <= NP'(dxa2_r) * NP'(post_r);
      n3_r   <= NP'(pre_r) * NP'(dyb2_r);
      n4_r   <= NP'(dya2_r) * NP'(post_r);
      xlo3_r <= xlo2_r;
      xhi3_r <= xhi2_r;
      ylo3_r <= ylo2_r;
      yhi3_r <= yhi2_r;

      // fold the sign of the determinant into the numerators
      nx4_r  <= d_r[DW-1] ? NW'(n2_r) - NW'(n1_r) : NW'(n1_r) - NW'(n2_r);
      ny4_r  <= d_r[DW-1] ? NW'(n4_r) - NW'(n3_r) : NW'(n3_r) - NW'(n4_r);
      ad4_r  <= d_r[DW-1] ? -d_r : d_r;
      par4_r <= (d_r == '0);
      xlo4_r <= xlo3_r;
      xhi4_r <= xhi3_r;
      ylo4_r <= ylo3_r;
      yhi4_r <= yhi3_r;

      nx5_r  <= nx4_r;
      ny5_r  <= ny4_r;
      ad5_r  <= ad4_r;
      par5_r <= par4_r;
      bxlo_r <= BP'(xlo4_r) * BP'(ad4_r);
      bxhi_r <= BP'(xhi4_r) * BP'(ad4_r);
      bylo_r <= BP'(ylo4_r) * BP'(ad4_r);
      byhi_r <= BP'(yhi4_r) * BP'(ad4_r);

      nx6_r  <= nx5_r;
      ny6_r  <= ny5_r;
      ad6_r  <= ad5_r;
      st6_r  <= st_nxt;
    end
  end

endmodule

// File: rtl/lsi_queue.sv
// ----------------------------------------------------------------------------
// lsi_queue
// small register fifo between the front and back pipelines
// ----------------------------------------------------------------------------
module lsi_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import lsi_pkg::*;

  logic [W-1:0]      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// File: rtl/lsi_back.sv
// ----------------------------------------------------------------------------
// lsi_back
// pipelined restoring divider, one quotient bit per stage for x and y
// ----------------------------------------------------------------------------
module lsi_back #(
  parameter int CB = 16,
  parameter int NW = 3 * CB + 4,
  parameter int DW = 2 * CB + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [1:0]           q_status,
  input  logic signed [NW-1:0] q_nx,
  input  logic signed [NW-1:0] q_ny,
  input  logic signed [DW-1:0] q_den,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic signed [CB-1:0] out_cross_x,
  output logic signed [CB-1:0] out_cross_y
);
  import lsi_pkg::*;

  localparam int NS = CB + 2;
  localparam int QW = CB + 1;

  logic              en;
  logic [NS-1:0]     v_r;
  logic [NW-1:0]     rx_r [NS];
  logic [NW-1:0]     ry_r [NS];
  logic [QW-1:0]     qx_r [NS];
  logic [QW-1:0]     qy_r [NS];
  logic [DW-1:0]     den_r [NS];
  logic              negx_r [NS];
  logic              negy_r [NS];
  lsi_status_t       st_r [NS];
  logic [QW-1:0]     fx, fy;

  assign en    = out_ready || !v_r[NS-1];
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]   <= q_nx[NW-1] ? NW'(-q_nx) : NW'(q_nx);
      ry_r[0]   <= q_ny[NW-1] ? NW'(-q_ny) : NW'(q_ny);
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      den_r[0]  <= DW'(q_den);
      negx_r[0] <= q_nx[NW-1];
      negy_r[0] <= q_ny[NW-1];
      st_r[0]   <= lsi_status_t'(q_status);
    end
  end

  for (genvar j = 0; j < NS - 1; j++) begin : g_step
    localparam int K = CB - j;
    logic [NW-1:0] sh;
    logic          tx, ty;
    assign sh = NW'(den_r[j]) << K;
    assign tx = (sh <= rx_r[j]);
    assign ty = (sh <= ry_r[j]);
    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[j+1]   <= tx ? rx_r[j] - sh : rx_r[j];
        ry_r[j+1]   <= ty ? ry_r[j] - sh : ry_r[j];
        qx_r[j+1]   <= qx_r[j] | (QW'(tx) << K);
        qy_r[j+1]   <= qy_r[j] | (QW'(ty) << K);
        den_r[j+1]  <= den_r[j];
        negx_r[j+1] <= negx_r[j];
        negy_r[j+1] <= negy_r[j];
        st_r[j+1]   <= st_r[j];
      end
    end
  end

  assign fx = negx_r[NS-1] ? -qx_r[NS-1] : qx_r[NS-1];
  assign fy = negy_r[NS-1] ? -qy_r[NS-1] : qy_r[NS-1];

  assign out_valid   = v_r[NS-1];
  assign out_status  = st_r[NS-1];
  assign out_cross_x = (st_r[NS-1] == ST_HIT) ? fx[CB-1:0] : '0;
  assign out_cross_y = (st_r[NS-1] == ST_HIT) ? fy[CB-1:0] : '0;

endmodule

// File: rtl/line_segment_intersect.sv
// ----------------------------------------------------------------------------
// line_segment_intersect
// exact crossing point of two line segments
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle while in_ready is high and returns one
// result per pair in order. A six stage front computes the determinant, the
// Cramer numerators and the bounds test; a four entry queue then feeds a
// back pipeline that divides one quotient bit per stage (COORD_BITS + 2
// stages). A stalled output holds the back pipeline while the front keeps
// taking items until the queue fills.
// ----------------------------------------------------------------------------
module line_segment_intersect #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lsi_in_if.sink    in_ch,
  lsi_out_if.source out_ch
);
  import lsi_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int NW = 3 * CB + 4;
  localparam int DW = 2 * CB + 3;
  localparam int QW = 2 + 2 * NW + DW;

  logic                 push, pop, full, empty;
  logic [1:0]           f_status;
  logic signed [NW-1:0] f_nx, f_ny;
  logic signed [DW-1:0] f_den;
  logic [QW-1:0]        rdata;

  lsi_front #(.CB(CB), .NW(NW), .DW(DW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .x1       (in_ch.a0_x),
    .y1       (in_ch.a0_y),
    .x2       (in_ch.a1_x),
    .y2       (in_ch.a1_y),
    .x3       (in_ch.b0_x),
    .y3       (in_ch.b0_y),
    .x4       (in_ch.b1_x),
    .y4       (in_ch.b1_y),
    .q_full   (full),
    .q_push   (push),
    .q_status (f_status),
    .q_nx     (f_nx),
    .q_ny     (f_ny),
    .q_den    (f_den)
  );

  lsi_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_status, f_nx, f_ny, f_den}),
    .pop   (pop),
    .rdata (rdata),
    .full  (full),
    .empty (empty)
  );

  lsi_back #(.CB(CB), .NW(NW), .DW(DW)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (empty),
    .q_pop       (pop),
    .q_status    (rdata[QW-1 -: 2]),
    .q_nx        (rdata[QW-3 -: NW]),
    .q_ny        (rdata[QW-3-NW -: NW]),
    .q_den       (rdata[DW-1:0]),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_cross_x (out_ch.cross_x),
    .out_cross_y (out_ch.cross_y)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_HIT) |->
      (out_ch.cross_x == '0) && (out_ch.cross_y == '0))
    else $error("crossing point not zero on a miss");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule
